// ----- hdl/dqs_pkg.sv -----
package dqs_pkg;

   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int OCC_W    = 5;
   localparam int REQ_W    = 40;   // action + value, padded to whole bytes
   localparam int RSP_W    = 48;   // status + popped + position + occupancy, padded

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_SEARCH     = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_UNDER    = 2'd1,
      ST_OVER     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_WAIT,
      S_SEARCH,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  popped_value;
      logic        [POS_W-1:0]    found_position;
      logic        [OCC_W-1:0]    occupancy;
   } result_type;

endpackage

// ----- hdl/double_ended_queue_with_search.sv -----
// channel  direction  tdata fields (low bit up)                                tuser
// req_     in         action[2:0] value[34:3] pad[39:35]                         -
// rsp_     out        status[1:0] popped_value[33:2] found_position[37:34]      -
//                     occupancy[42:38] pad[47:43]
//
// push goes S_IDLE then S_DONE; pop goes S_IDLE, S_POP_WAIT, S_DONE; search goes S_IDLE,
// S_SEARCH over n entries walked (up to DEPTH), S_DONE, one entry memory read per cycle
// reset clears the state, front pointer, count and output valid; the entry memory is left as is
// a stalled result waits in the output register while the next item is taken
// and worked on; that item then holds until the register frees
module double_ended_queue_with_search
   import dqs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // action, value
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // status, popped_value, found_position, occupancy
);

   localparam int AW = $clog2(DEPTH);

   // entry memory port
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;

   // engine result hand-off
   logic       res_valid;
   logic       out_free;
   result_type res;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   dqs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dqs_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tdata[ACTION_W-1:0]),
      .req_value  (req_tdata[ACTION_W+VALUE_W-1:ACTION_W]),
      .res_valid  (res_valid),
      .out_free   (out_free),
      .res        (res),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - STATUS_W - VALUE_W - POS_W - OCC_W){1'b0}},
                        rsp_data_ff.occupancy,
                        rsp_data_ff.found_position,
                        rsp_data_ff.popped_value,
                        rsp_data_ff.status};

endmodule

// ----- hdl/dqs_ram.sv -----
module dqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/dqs_engine.sv -----
module dqs_engine
   import dqs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic [VALUE_W-1:0]        req_value,
   output logic                      res_valid,
   input  logic                      out_free,
   output result_type                res,
   output logic                      wr_en,
   output logic [$clog2(DEPTH)-1:0]  wr_addr,
   output logic [VALUE_W-1:0]        wr_data,
   output logic [$clog2(DEPTH)-1:0]  rd_addr,
   input  logic [VALUE_W-1:0]        rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   state_type         state_ff, state_in;
   logic [AW-1:0]     front_ff, front_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   result_type        res_ff, res_in;
   logic [AW-1:0]     sidx_ff, sidx_in;
   logic [CW-1:0]     off_ff, off_in;

   logic [SW-1:0]     back_sum;
   logic [AW-1:0]     back_idx;
   logic [AW-1:0]     last_idx;
   logic              full;
   logic              empty;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
      return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
   endfunction

   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] idx);
      return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
   endfunction

   // ring index one past the back entry
   assign back_sum = SW'(front_ff) + SW'(count_ff);
   assign back_idx = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
   assign last_idx = wrap_dec(back_idx);
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
      key_ff  <= key_in;
      res_ff  <= res_in;
      sidx_ff <= sidx_in;
      off_ff  <= off_in;
   end

   always_comb begin
      state_in  = state_ff;
      front_in  = front_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      res_in    = res_ff;
      sidx_in   = sidx_ff;
      off_in    = off_ff;
      wr_en     = 1'b0;
      wr_addr   = back_idx;
      wr_data   = req_value;
      rd_addr   = front_ff;
      req_ready = (state_ff == S_IDLE);
      res_valid = (state_ff == S_DONE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in.status         = ST_OK;
               res_in.popped_value   = '0;
               res_in.found_position = '0;
               res_in.occupancy      = OCC_W'(count_ff);
               state_in              = S_DONE;
               case (action_type'(req_action))
                  ACT_PUSH_FRONT: begin
                     if (full) begin
                        res_in.status = ST_OVER;
                     end else begin
                        wr_en            = 1'b1;
                        wr_addr          = wrap_dec(front_ff);
                        front_in         = wrap_dec(front_ff);
                        count_in         = count_ff + CW'(1);
                        res_in.occupancy = OCC_W'(count_ff + CW'(1));
                     end
                  end
                  ACT_PUSH_BACK: begin
                     if (full) begin
                        res_in.status = ST_OVER;
                     end else begin
                        wr_en            = 1'b1;
                        wr_addr          = back_idx;
                        count_in         = count_ff + CW'(1);
                        res_in.occupancy = OCC_W'(count_ff + CW'(1));
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (empty) begin
                        res_in.status = ST_UNDER;
                     end else begin
                        rd_addr          = front_ff;
                        front_in         = wrap_inc(front_ff);
                        count_in         = count_ff - CW'(1);
                        res_in.occupancy = OCC_W'(count_ff - CW'(1));
                        state_in         = S_POP_WAIT;
                     end
                  end
                  ACT_POP_BACK: begin
                     if (empty) begin
                        res_in.status = ST_UNDER;
                     end else begin
                        rd_addr          = last_idx;
                        count_in         = count_ff - CW'(1);
                        res_in.occupancy = OCC_W'(count_ff - CW'(1));
                        state_in         = S_POP_WAIT;
                     end
                  end
                  ACT_SEARCH: begin
                     key_in = req_value;
                     if (empty) begin
                        res_in.status = ST_NOTFOUND;
                     end else begin
                        rd_addr  = front_ff;
                        sidx_in  = wrap_inc(front_ff);
                        off_in   = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP_WAIT: begin
            res_in.popped_value = rd_data;
            state_in            = S_DONE;
         end
         S_SEARCH: begin
            // rd_data holds the entry at offset off_ff
            if (rd_data == key_ff) begin
               res_in.status         = ST_OK;
               res_in.found_position = POS_W'(off_ff);
               state_in              = S_DONE;
            end else if (off_ff == count_ff - CW'(1)) begin
               res_in.status = ST_NOTFOUND;
               state_in      = S_DONE;
            end else begin
               rd_addr = sidx_ff;
               sidx_in = wrap_inc(sidx_ff);
               off_in  = off_ff + CW'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule
